// ----- rtl/brfd_pkg.sv -----
// Package for the block residual frame decoder: phases, controller states, commands.
`default_nettype none
package brfd_pkg;
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_STEP  = 3'd1,
        ST_READ  = 3'd2,
        ST_WRITE = 3'd3,
        ST_EMIT  = 3'd4,
        ST_LOOK  = 3'd5
    } t_state;

    localparam logic [1:0] REF_NONE = 2'd0;
    localparam logic [1:0] REF_UL   = 2'd1;
    localparam logic [1:0] REF_UP   = 2'd2;
    localparam logic [1:0] REF_LEFT = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;   // take input word
        logic step;   // one header step (also locates block)
        logic pix;    // one pixel prepare step
        logic write;  // commit pixel to store
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic active;   // phase header or pixels after load
        logic can_hdr;  // header step possible
        logic can_pix;  // pixel step possible
        logic done;     // frame finished
    } t_stat;
endpackage
`default_nettype wire

// ----- rtl/block_residual_frame_decoder.sv -----
// Top level of the block residual frame decoder.
// Takes one bitstream byte per accepted word and emits up to eight reconstructed
// pixels for it. Each pixel passes through a prepare step, a frame store read,
// a write and a look-ahead state before it is offered, then waits in the output
// handshake; block headers are decoded in the prepare and look-ahead states. The
// single-port frame store read-modify-write limits the pixel rate, and the next
// word is accepted only after the last result of the current word, if any, is taken.
`default_nettype none
module block_residual_frame_decoder
    import brfd_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 512,
    parameter int BLOCK_WIDTH  = 8,
    parameter int BLOCK_HEIGHT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_of_frame,
    input  wire logic        i_frame_intra,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_pixel_value,
    output logic [9:0]       o_pixel_column,
    output logic [8:0]       o_pixel_row,
    output logic             o_last_of_run,
    output logic             o_frame_done
);
    logic [10:0] r_width;
    logic [9:0]  r_height;
    t_cmd  w_cmd;
    t_stat w_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 10'd480;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'b0) r_width <= i_cfg_data;
            else r_height <= i_cfg_data[9:0];
        end
    end

    brfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_last  (o_last_of_run)
    );

    brfd_dp #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .BLOCK_WIDTH  (BLOCK_WIDTH),
        .BLOCK_HEIGHT (BLOCK_HEIGHT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_data_byte      (i_data_byte),
        .i_start_of_frame (i_start_of_frame),
        .i_frame_intra    (i_frame_intra),
        .i_width          (r_width),
        .i_height         (r_height),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_pixel_value    (o_pixel_value),
        .o_pixel_column   (o_pixel_column),
        .o_pixel_row      (o_pixel_row),
        .o_frame_done     (o_frame_done)
    );
endmodule
`default_nettype wire

// ----- rtl/brfd_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module brfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/brfd_ctrl.sv -----
// Controller state machine: sequences load, decode steps and result handshake.
`default_nettype none
module brfd_ctrl
    import brfd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  wire logic  i_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_last
);
    t_state r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic r_done, n_done;
    logic r_last, n_last;

    // decoding may go on for this word
    logic w_go;
    assign w_go = !r_done && r_cnt != 4'd8 && i_stat.active;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = r_done;
        n_last  = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_STEP;
                    n_cnt   = 4'd0;
                    n_done  = 1'b0;
                end
            end
            ST_STEP: begin
                if (!w_go) begin
                    n_state = ST_IDLE;
                end else if (i_stat.can_pix) begin
                    n_state = ST_READ;
                end else if (!i_stat.can_hdr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: begin
                n_state = ST_LOOK;
                n_cnt   = r_cnt + 4'd1;
                n_done  = i_stat.done;
            end
            // run pending headers so the last flag is known before the offer
            ST_LOOK: begin
                if (!w_go) begin
                    n_state = ST_EMIT;
                    n_last  = 1'b1;
                end else if (i_stat.can_pix) begin
                    n_state = ST_EMIT;
                    n_last  = 1'b0;
                end else if (!i_stat.can_hdr) begin
                    n_state = ST_EMIT;
                    n_last  = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_ready) begin
                    n_state = ST_STEP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready       = (r_state == ST_IDLE);
        o_cmd.load    = (r_state == ST_IDLE) && i_valid;
        o_cmd.step    = (r_state == ST_STEP || r_state == ST_LOOK) && w_go &&
                        i_stat.can_hdr;
        o_cmd.pix     = (r_state == ST_STEP) && w_go && i_stat.can_pix;
        o_cmd.write   = (r_state == ST_WRITE);
        o_valid       = (r_state == ST_EMIT);
        o_last        = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 4'd0;
            r_done  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            r_last  <= n_last;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/brfd_dp.sv -----
// Datapath: bit buffer, block position, frame store and pixel reconstruction.
`default_nettype none
module brfd_dp
    import brfd_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 512,
    parameter int BLOCK_WIDTH  = 8,
    parameter int BLOCK_HEIGHT = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_start_of_frame,
    input  wire logic        i_frame_intra,
    input  wire logic [10:0] i_width,
    input  wire logic [9:0]  i_height,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic [7:0]       o_pixel_value,
    output logic [9:0]       o_pixel_column,
    output logic [8:0]       o_pixel_row,
    output logic             o_frame_done
);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int NPB = BLOCK_WIDTH * BLOCK_HEIGHT;
    localparam int PW  = $clog2(NPB + 1);
    localparam int BCW = CW + 1;
    localparam int BRW = RW + 1;
    localparam int AW  = XW + YW;

    // effective frame size, clamped
    logic [CW-1:0] w_w;
    logic [RW-1:0] w_h;
    always_comb begin
        if (i_width == 11'd0) w_w = CW'(1);
        else if (32'(i_width) > MAX_WIDTH) w_w = CW'(MAX_WIDTH);
        else w_w = CW'(i_width);
        if (i_height == 10'd0) w_h = RW'(1);
        else if (32'(i_height) > MAX_HEIGHT) w_h = RW'(MAX_HEIGHT);
        else w_h = RW'(i_height);
    end

    logic [15:0] r_buf;
    logic [4:0]  r_held;
    t_phase      r_phase;
    logic        r_intra;
    logic [BCW-1:0] r_bcol;   // block origin column in pixels
    logic [BRW-1:0] r_brow;   // block origin row
    logic [PW-1:0]  r_pib;
    logic [2:0]     r_len;
    logic [1:0]     r_ref;
    // pixel staging
    logic [XW-1:0]  r_pc;
    logic [YW-1:0]  r_pr;
    logic [AW-1:0]  r_ba;     // base pixel address
    logic [7:0]     r_v;
    logic           r_bz;     // base forced to zero
    logic           r_fin;
    logic [7:0]     r_val;

    // pixel position of r_pib (block sizes are constants)
    logic [BCW-1:0] w_c;
    logic [BRW-1:0] w_r;
    assign w_c = r_bcol + BCW'(32'(r_pib) % BLOCK_WIDTH);
    assign w_r = r_brow + BRW'(32'(r_pib) / BLOCK_WIDTH);

    // origin in frame, with row wrap of the origin
    logic w_origin_row_in, w_origin_col_in;
    assign w_origin_row_in = 32'(r_brow) < 32'(w_h);
    assign w_origin_col_in = 32'(r_bcol) < 32'(w_w);

    // next in-frame pixel at or after r_pib+1 within this block (row-major)
    logic [PW-1:0] w_nxt;
    always_comb begin
        logic [PW-1:0] q;
        w_nxt = PW'(NPB);
        q = r_pib + PW'(1);
        // stay in row if next column in frame, else jump to next row start
        if (32'(q) % BLOCK_WIDTH != 0 && 32'(w_r) < 32'(w_h) &&
            32'(w_c) + 1 < 32'(w_w)) begin
            w_nxt = q;
        end else if (w_origin_col_in &&
                     32'(r_pib) / BLOCK_WIDTH + 1 < BLOCK_HEIGHT &&
                     32'(w_r) + 1 < 32'(w_h)) begin
            w_nxt = PW'((32'(r_pib) / BLOCK_WIDTH + 1) * BLOCK_WIDTH);
        end
    end

    logic [2:0] w_need;
    assign w_need = r_intra ? 3'd5 : 3'd3;
    logic [3:0] w_pbits;
    assign w_pbits = {1'b0, r_len} + 4'd1;

    assign o_stat.active  = (r_phase == PH_HEADER) || (r_phase == PH_PIXELS);
    assign o_stat.can_hdr = (r_phase == PH_HEADER) &&
                            (!w_origin_row_in || !w_origin_col_in ||
                             r_held >= {2'b0, w_need});
    assign o_stat.can_pix = (r_phase == PH_PIXELS) && r_held >= {1'b0, w_pbits};
    assign o_stat.done    = r_fin;

    // extracted pixel value, sign extended
    logic [15:0] w_sh;
    logic [7:0]  w_raw, w_sx;
    logic [7:0]  w_mask;
    assign w_sh   = r_buf >> (r_held - 5'(w_pbits));
    assign w_mask = 8'((9'd1 << w_pbits) - 9'd1);
    assign w_raw  = w_sh[7:0] & w_mask;
    assign w_sx   = (r_len != 3'd7 && w_raw[r_len]) ? (w_raw | ~w_mask) : w_raw;

    // read address for the base pixel
    logic [BCW-1:0] w_bc;
    logic [BRW-1:0] w_br;
    logic           w_bz;
    always_comb begin
        w_bc = w_c;
        w_br = w_r;
        w_bz = 1'b0;
        if (r_intra) begin
            case (r_ref)
                REF_UL: begin
                    w_bz = 32'(w_r) < BLOCK_HEIGHT || 32'(w_c) < BLOCK_WIDTH;
                    w_bc = w_c - BCW'(BLOCK_WIDTH);
                    w_br = w_r - BRW'(BLOCK_HEIGHT);
                end
                REF_UP: begin
                    w_bz = 32'(w_r) < BLOCK_HEIGHT;
                    w_br = w_r - BRW'(BLOCK_HEIGHT);
                end
                REF_LEFT: begin
                    w_bz = 32'(w_c) < BLOCK_WIDTH;
                    w_bc = w_c - BCW'(BLOCK_WIDTH);
                end
                default: w_bz = 1'b1;
            endcase
        end
    end

    logic        w_we;
    logic [AW-1:0] w_addr;
    logic [7:0]  w_rdata, w_sum;
    assign w_we   = i_cmd.write;
    assign w_addr = w_we ? {r_pr, r_pc} : r_ba;
    assign w_sum  = (r_bz ? 8'd0 : w_rdata) + r_v;

    brfd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_sum),
        .o_rdata (w_rdata)
    );

    // pixel prepare strobe from the controller
    logic w_pix_step;
    assign w_pix_step = i_cmd.pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= 16'd0;
            r_held  <= 5'd0;
            r_phase <= PH_HEADER;
            r_intra <= 1'b0;
            r_bcol  <= '0;
            r_brow  <= '0;
            r_pib   <= '0;
            r_len   <= 3'd0;
            r_ref   <= 2'd0;
            r_fin   <= 1'b0;
        end else if (i_cmd.load) begin
            if (i_start_of_frame) begin
                r_intra <= i_frame_intra;
                r_bcol  <= '0;
                r_brow  <= '0;
                r_pib   <= '0;
                r_len   <= 3'd0;
                r_ref   <= 2'd0;
                r_phase <= PH_HEADER;
                r_buf   <= {8'd0, i_data_byte};
                r_held  <= 5'd8;
            end else if (o_stat.active) begin
                r_buf   <= {r_buf[7:0], i_data_byte};
                r_held  <= (r_held + 5'd8 > 5'd16) ? 5'd16 : r_held + 5'd8;
            end
            r_fin <= 1'b0;
        end else if (i_cmd.step) begin
            // header step (also locates block)
            if (!w_origin_row_in) begin
                r_phase <= PH_DONE;
            end else if (!w_origin_col_in) begin
                r_bcol <= '0;
                r_brow <= r_brow + BRW'(BLOCK_HEIGHT);
            end else begin
                if (r_intra) begin
                    r_ref <= 2'(r_buf >> (r_held - 5'd2));
                    r_len <= 3'(r_buf >> (r_held - 5'd5));
                    r_held <= r_held - 5'd5;
                    r_buf <= r_buf & 16'((17'd1 << (r_held - 5'd5)) - 17'd1);
                end else begin
                    r_ref <= REF_NONE;
                    r_len <= 3'(r_buf >> (r_held - 5'd3));
                    r_held <= r_held - 5'd3;
                    r_buf <= r_buf & 16'((17'd1 << (r_held - 5'd3)) - 17'd1);
                end
                r_pib   <= '0;
                r_phase <= PH_PIXELS;
            end
        end else if (w_pix_step) begin
            // pixel prepare: consume bits, stage address, advance position
            r_held <= r_held - 5'(w_pbits);
            r_buf  <= r_buf & 16'((17'd1 << (r_held - 5'(w_pbits))) - 17'd1);
            r_v    <= w_sx;
            r_bz   <= w_bz;
            r_pc   <= w_c[XW-1:0];
            r_pr   <= w_r[YW-1:0];
            r_ba   <= {w_br[YW-1:0], w_bc[XW-1:0]};
            r_fin  <= 1'b0;
            if (w_nxt == PW'(NPB)) begin
                r_pib <= '0;
                if (w_origin_row_in && 32'(r_bcol) + BLOCK_WIDTH < 32'(w_w)) begin
                    r_bcol  <= r_bcol + BCW'(BLOCK_WIDTH);
                    r_phase <= PH_HEADER;
                end else if (32'(r_brow) + BLOCK_HEIGHT < 32'(w_h)) begin
                    r_bcol  <= '0;
                    r_brow  <= r_brow + BRW'(BLOCK_HEIGHT);
                    r_phase <= PH_HEADER;
                end else begin
                    r_phase <= PH_DONE;
                    r_fin   <= 1'b1;
                end
            end else begin
                r_pib <= w_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_val <= w_sum;
        end
    end

    assign o_pixel_value  = r_val;
    assign o_pixel_column = 10'(r_pc);
    assign o_pixel_row    = 9'(r_pr);
    assign o_frame_done   = r_fin;
endmodule
`default_nettype wire
